/* src/ufge_pkg.sv */
// shared types, codes and reset values for the idle gap frame engine
package ufge_pkg;

    // default store size and register reset values
    localparam int unsigned RECV_DEPTH_DEF = 64;
    localparam logic [7:0]  CHAR_GAP_RST   = 8'd3;
    localparam logic [7:0]  ERR_HOLD_RST   = 8'd10;

    // configuration register indexes
    localparam logic CFG_CHAR_GAP = 1'b0;
    localparam logic CFG_ERR_HOLD = 1'b1;

    // request kinds
    localparam logic [2:0] KIND_RX_BYTE  = 3'd0;
    localparam logic [2:0] KIND_OVERRUN  = 3'd1;
    localparam logic [2:0] KIND_TICK     = 3'd2;
    localparam logic [2:0] KIND_SCAN     = 3'd3;
    localparam logic [2:0] KIND_FETCH    = 3'd4;
    localparam logic [2:0] KIND_TX_START = 3'd5;
    localparam logic [2:0] KIND_TX_READY = 3'd6;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_READY = 3'd1;
    localparam logic [2:0] ST_TX_BUSY   = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_NONE      = 3'd4;

    // receive phases
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_BUSY     = 2'd1;
    localparam logic [1:0] PH_COMPLETE = 2'd2;
    localparam logic [1:0] PH_READY    = 2'd3;

    // request payload
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  rx_data;
        logic [15:0] tx_length;
    } t_req;

    // result payload
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic        read_last;
        logic [6:0]  frame_length;
        logic        send_valid;
        logic [15:0] send_index;
        logic [1:0]  rx_phase;
        logic        tx_busy;
    } t_res;

endpackage

/* src/ufge_ram.sv */
// generic single write, single read ram with registered read data
module ufge_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/uart_idle_gap_frame_engine_top.sv */
// frame engine top level: receive store, frame publish and fetch, transmit pacing
//
//  channel  | signals                              | handshake
//  ---------+--------------------------------------+----------------------------
//  request  | i_start, o_busy, i_req               | taken when start & !busy
//  result   | o_res_valid, o_res                   | one-cycle strobe, no stall
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data      | written when we is high
//
// most requests give their single result on the cycle after they are taken and
// leave the engine free at once. a fetch of n bytes reads the store ram one
// byte per cycle via the read state, registered ram port and pending stage;
// results follow one per cycle and busy drops on the cycle the last byte shows.
// synchronous active-low reset clears most control state, not the fetch index,
// frame length, last flag, result or store; the receiver cannot hold off results.
module uart_idle_gap_frame_engine_top
    import ufge_pkg::*;
#(
    parameter int unsigned RECV_DEPTH = RECV_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  t_req       i_req,
    output logic       o_res_valid,
    output t_res       o_res,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    localparam int unsigned AW = $clog2(RECV_DEPTH);
    localparam int unsigned CW = $clog2(RECV_DEPTH + 1);

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state         r_state, n_state;
    logic           r_busy, n_busy;
    logic           r_res_vld, n_res_vld;
    t_res           r_res, n_res;
    logic [7:0]     r_gap, n_gap;
    logic [7:0]     r_hold, n_hold;
    logic [1:0]     r_phase, n_phase;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [7:0]     r_rtimer, n_rtimer;
    logic           r_ovf, n_ovf;
    logic [6:0]     r_pub, n_pub;
    logic [7:0]     r_stimer, n_stimer;
    logic           r_sending, n_sending;
    logic           r_armed, n_armed;
    logic [15:0]    r_scount, n_scount;
    logic [15:0]    r_slen, n_slen;
    logic [AW-1:0]  r_idx, n_idx;
    logic [6:0]     r_flen, n_flen;
    logic           r_pend, n_pend;
    logic           r_pend_last, n_pend_last;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;

    ufge_ram #(
        .WIDTH (8),
        .DEPTH (RECV_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_req.rx_data),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state for the whole engine
    always_comb begin
        logic          v_acc;
        logic          v_emit;
        logic [2:0]    v_status;
        logic          v_svalid;
        logic [15:0]   v_sidx;
        logic [CW-1:0] v_cnt;
        logic [1:0]    v_phase;

        v_acc    = i_start && !r_busy;
        v_emit   = 1'b0;
        v_status = ST_NONE;
        v_svalid = 1'b0;
        v_sidx   = '0;
        v_cnt    = r_cnt;
        v_phase  = r_phase;

        n_state     = r_state;
        n_res_vld   = 1'b0;
        n_res       = r_res;
        n_gap       = r_gap;
        n_hold      = r_hold;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_rtimer    = r_rtimer;
        n_ovf       = r_ovf;
        n_pub       = r_pub;
        n_stimer    = r_stimer;
        n_sending   = r_sending;
        n_armed     = r_armed;
        n_scount    = r_scount;
        n_slen      = r_slen;
        n_idx       = r_idx;
        n_flen      = r_flen;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;

        ram_we    = 1'b0;
        ram_waddr = r_cnt[AW-1:0];
        ram_raddr = r_idx;

        // register writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHAR_GAP: n_gap  = i_cfg_data;
                CFG_ERR_HOLD: n_hold = i_cfg_data;
                default:      n_gap  = r_gap;
            endcase
        end

        // fetch stream: read one store byte a cycle
        if (r_state == S_READ) begin
            n_pend      = 1'b1;
            n_pend_last = (7'(r_idx) == r_flen - 7'd1);
            if (n_pend_last) begin
                n_state = S_IDLE;
            end else begin
                n_idx = AW'(r_idx + 1'b1);
            end
        end

        // byte read last cycle goes out as a result
        if (r_pend) begin
            n_res_vld          = 1'b1;
            n_res.status       = ST_OK;
            n_res.read_byte    = ram_rdata;
            n_res.read_valid   = 1'b1;
            n_res.read_last    = r_pend_last;
            n_res.frame_length = r_flen;
            n_res.send_valid   = 1'b0;
            n_res.send_index   = '0;
            n_res.rx_phase     = r_phase;
            n_res.tx_busy      = r_sending;
        end

        // request handling
        if (v_acc) begin
            v_emit = 1'b1;
            unique case (i_req.kind)
                KIND_RX_BYTE: begin
                    if (r_phase == PH_IDLE || r_phase == PH_BUSY) begin
                        if (r_phase == PH_IDLE) begin
                            v_cnt = '0;
                        end
                        if (v_cnt >= CW'(RECV_DEPTH)) begin
                            v_cnt = '0;
                        end
                        ram_we    = 1'b1;
                        ram_waddr = v_cnt[AW-1:0];
                        n_cnt     = CW'(v_cnt + 1'b1);
                        n_phase   = PH_BUSY;
                        n_rtimer  = r_gap;
                    end
                end
                KIND_OVERRUN: begin
                    n_ovf = 1'b1;
                end
                KIND_TICK: begin
                    if (r_stimer != 8'd0) begin
                        n_stimer = r_stimer - 8'd1;
                        if (r_stimer == 8'd1 && r_sending) begin
                            n_sending = 1'b0;
                            n_armed   = 1'b0;
                            n_scount  = '0;
                        end
                    end
                    if (r_rtimer != 8'd0) begin
                        n_rtimer = r_rtimer - 8'd1;
                        if (r_rtimer == 8'd1 && r_phase == PH_BUSY) begin
                            n_phase = PH_COMPLETE;
                        end
                    end
                end
                KIND_SCAN: begin
                    if (r_ovf) begin
                        v_phase  = PH_IDLE;
                        n_rtimer = r_hold;
                        n_cnt    = '0;
                        n_ovf    = 1'b0;
                    end
                    if (v_phase == PH_COMPLETE) begin
                        n_pub   = 7'(r_cnt);
                        v_phase = PH_READY;
                    end
                    n_phase = v_phase;
                end
                KIND_FETCH: begin
                    if (r_sending) begin
                        v_status = ST_TX_BUSY;
                    end else if (r_phase == PH_READY) begin
                        n_pub    = '0;
                        n_phase  = PH_IDLE;
                        v_status = ST_OK;
                        if (r_pub != 7'd0) begin
                            v_emit  = 1'b0;
                            n_state = S_READ;
                            n_idx   = '0;
                            n_flen  = r_pub;
                        end
                    end else begin
                        v_status = ST_NOT_READY;
                    end
                end
                KIND_TX_START: begin
                    if (r_sending) begin
                        v_status = ST_TX_BUSY;
                    end else if (i_req.tx_length == 16'd0) begin
                        v_status = ST_BAD_LEN;
                    end else begin
                        n_stimer  = r_gap;
                        n_slen    = i_req.tx_length;
                        n_scount  = '0;
                        n_armed   = 1'b1;
                        n_sending = 1'b1;
                        v_status  = ST_OK;
                    end
                end
                KIND_TX_READY: begin
                    if (r_armed) begin
                        if (r_scount < r_slen) begin
                            v_svalid = 1'b1;
                            v_sidx   = r_scount;
                            n_scount = r_scount + 16'd1;
                            n_stimer = r_gap;
                        end else begin
                            n_armed   = 1'b0;
                            n_sending = 1'b0;
                        end
                    end
                end
                default: begin
                    v_status = ST_NONE;
                end
            endcase
        end

        // single result of a request
        if (v_emit) begin
            n_res_vld          = 1'b1;
            n_res.status       = v_status;
            n_res.read_byte    = '0;
            n_res.read_valid   = 1'b0;
            n_res.read_last    = 1'b1;
            n_res.frame_length = '0;
            n_res.send_valid   = v_svalid;
            n_res.send_index   = v_sidx;
            n_res.rx_phase     = n_phase;
            n_res.tx_busy      = n_sending;
        end

        n_busy = (n_state == S_READ) || n_pend;
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_res_vld   <= 1'b0;
            r_gap       <= CHAR_GAP_RST;
            r_hold      <= ERR_HOLD_RST;
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_rtimer    <= '0;
            r_ovf       <= 1'b0;
            r_pub       <= '0;
            r_stimer    <= '0;
            r_sending   <= 1'b0;
            r_armed     <= 1'b0;
            r_scount    <= '0;
            r_slen      <= '0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_res_vld   <= n_res_vld;
            r_gap       <= n_gap;
            r_hold      <= n_hold;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_rtimer    <= n_rtimer;
            r_ovf       <= n_ovf;
            r_pub       <= n_pub;
            r_stimer    <= n_stimer;
            r_sending   <= n_sending;
            r_armed     <= n_armed;
            r_scount    <= n_scount;
            r_slen      <= n_slen;
            r_pend      <= n_pend;
        end
        r_res       <= n_res;
        r_idx       <= n_idx;
        r_flen      <= n_flen;
        r_pend_last <= n_pend_last;
    end

    assign o_busy      = r_busy;
    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

endmodule

/* src/ufge_checker.sv */
// port level checks for the frame engine, bound to the top level
module ufge_checker
    import ufge_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_res_valid,
    input t_res o_res
);

    // a taken request either answers next cycle or holds the engine busy
    a_req_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_res_valid || o_busy)
        else $error("request taken without result or busy");

    // frame bytes stream without gaps until the last one
    a_stream_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.read_valid && !o_res.read_last
        |=> o_res_valid && o_res.read_valid)
        else $error("gap inside fetched frame");

    // frame bytes carry ok status and a non-zero length
    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.read_valid
        |-> o_res.status == ST_OK && o_res.frame_length != 7'd0)
        else $error("frame byte with bad status or length");

    // a send index only comes while transmitting and stands alone
    a_send_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.send_valid
        |-> o_res.tx_busy && o_res.read_last && !o_res.read_valid)
        else $error("send index outside transmission");

endmodule

bind uart_idle_gap_frame_engine_top ufge_checker u_ufge_checker (.*);
